// File: hw/rtl/bse_pkg.sv
// Shared types, constants and opcodes of the bounded sequence engine.
`default_nettype none
package bse_pkg;

  localparam int Capacity  = 256;
  localparam int ValueBits = 31;
  localparam int IdxBits   = 9;
  localparam int AddrBits  = 8;
  localparam int SeqBits   = 10;

  typedef enum logic [3:0] {
    OP_SETLEN = 4'd0, OP_WRITE = 4'd1, OP_READ = 4'd2, OP_TAIL = 4'd3,
    OP_CUT = 4'd4, OP_SWAP = 4'd5, OP_MAXIDX = 4'd6, OP_MINIDX = 4'd7,
    OP_SRCHUP = 4'd8, OP_SRCHDN = 4'd9, OP_SORTASC = 4'd10,
    OP_SORTDESC = 4'd11, OP_REVERSE = 4'd12, OP_SHIFTR = 4'd13,
    OP_SHIFTL = 4'd14, OP_NOP = 4'd15
  } opcode_t;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_GE = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;
  localparam logic [2:0] CMP_LE = 3'd4;
  localparam logic [2:0] CMP_LT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_DISPATCH, ST_COPY_RD, ST_COPY_WR, ST_SCAN_RD,
    ST_SCAN_CHK, ST_SWAP_RDA, ST_SWAP_RDB, ST_SWAP_WRA, ST_SWAP_WRB,
    ST_SORT_NEXT, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture the request
    logic init;       // set up pointers for the opcode
    logic copy_rd;    // read source of a copy
    logic copy_wr;    // write destination of a copy, advance
    logic scan_rd;    // read the scan pointer
    logic scan_chk;   // evaluate scanned element, advance
    logic swap_rda;
    logic swap_rdb;
    logic swap_wra;
    logic swap_wrb;
    logic sort_next;  // move the sort base on and restart the scan, or step the reverse pointers
    logic finish;     // form the result
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    range_open;  // the pointer still lies inside its range
    logic    next_open;   // another element follows the current one
    logic    hit;
    logic    sort_more;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/bse_if.sv
// Valid/ready channel interfaces for the request and result transfers.
`default_nettype none
interface bse_req_if;
  import bse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [3:0]           opcode;
  logic [IdxBits-1:0]   first_index;
  logic [IdxBits-1:0]   last_index;
  logic [IdxBits-1:0]   shift_amount;
  logic [ValueBits-1:0] operand_value;
  logic [2:0]           compare_kind;
  modport source (output valid, opcode, first_index, last_index, shift_amount,
                  operand_value, compare_kind, input ready);
  modport sink (input valid, opcode, first_index, last_index, shift_amount,
                operand_value, compare_kind, output ready);
endinterface

interface bse_rsp_if;
  import bse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [IdxBits-1:0]   result_index;
  logic [ValueBits-1:0] read_value;
  logic [IdxBits-1:0]   current_length;
  modport source (output valid, found, result_index, read_value,
                  current_length, input ready);
  modport sink (input valid, found, result_index, read_value,
                current_length, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bse_ctrl.sv
// Controller state machine that sequences the datapath for every opcode.
`default_nettype none
module bse_ctrl
  import bse_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  wire     out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECODE;
      ST_DECODE: state_next = ST_DISPATCH;
      // Pointers are set up by now, so the range checks are current.
      ST_DISPATCH: begin
        case (status.op)
          OP_TAIL, OP_CUT, OP_SHIFTR, OP_SHIFTL:
            state_next = status.range_open ? ST_COPY_RD : ST_DONE;
          OP_MAXIDX, OP_MINIDX, OP_SRCHUP, OP_SRCHDN:
            state_next = status.range_open ? ST_SCAN_RD : ST_DONE;
          OP_SORTASC, OP_SORTDESC:
            state_next = status.sort_more ? ST_SCAN_RD : ST_DONE;
          OP_SWAP:    state_next = ST_SWAP_RDA;
          OP_REVERSE: state_next = status.sort_more ? ST_SWAP_RDA : ST_DONE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: state_next = status.next_open ? ST_COPY_RD : ST_DONE;
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (status.next_open && !status.hit) begin
          state_next = ST_SCAN_RD;
        end else if (status.op == OP_SORTASC || status.op == OP_SORTDESC) begin
          state_next = ST_SWAP_RDA;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SWAP_RDA: state_next = ST_SWAP_RDB;
      ST_SWAP_RDB: state_next = ST_SWAP_WRA;
      ST_SWAP_WRA: state_next = ST_SWAP_WRB;
      ST_SWAP_WRB: begin
        if (status.op == OP_SWAP) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SORT_NEXT;
        end
      end
      ST_SORT_NEXT: state_next = ST_DISPATCH;
      ST_DONE: state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE:    cmd.init      = 1'b1;
      ST_COPY_RD:   cmd.copy_rd   = 1'b1;
      ST_COPY_WR:   cmd.copy_wr   = 1'b1;
      ST_SCAN_RD:   cmd.scan_rd   = 1'b1;
      ST_SCAN_CHK:  cmd.scan_chk  = 1'b1;
      ST_SWAP_RDA:  cmd.swap_rda  = 1'b1;
      ST_SWAP_RDB:  cmd.swap_rdb  = 1'b1;
      ST_SWAP_WRA:  cmd.swap_wra  = 1'b1;
      ST_SWAP_WRB:  cmd.swap_wrb  = 1'b1;
      ST_SORT_NEXT: cmd.sort_next = 1'b1;
      ST_DONE:      cmd.finish    = 1'b1;
      ST_OUT:       out_valid     = 1'b1;
      default:      cmd           = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/bse_datapath.sv
// Datapath: element memory, pointers, comparator and result registers.
`default_nettype none
module bse_datapath
  import bse_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  wire [3:0]            in_opcode,
  input  wire [IdxBits-1:0]    in_first,
  input  wire [IdxBits-1:0]    in_last,
  input  wire [IdxBits-1:0]    in_shift,
  input  wire [ValueBits-1:0]  in_value,
  input  wire [2:0]            in_kind,
  output logic                 found,
  output logic [IdxBits-1:0]   result_index,
  output logic [ValueBits-1:0] read_value,
  output logic [IdxBits-1:0]   current_length
);

  localparam logic [ValueBits-1:0] VMax = '1;
  localparam logic signed [SeqBits+1:0] One = {{(SeqBits+1){1'b0}}, 1'b1};

  // Element memory, one write port and one registered read port.
  logic [ValueBits-1:0] mem [Capacity];
  logic [ValueBits-1:0] rdata;
  logic [AddrBits-1:0]  raddr, waddr;
  logic                 we;
  logic [ValueBits-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Request fields.
  opcode_t              op;
  logic [IdxBits-1:0]   lo, hi, sh;
  logic [ValueBits-1:0] key;
  logic [2:0]           kind;
  logic [IdxBits-1:0]   len;

  // Working pointers, signed so that out-of-range positions are visible.
  logic signed [SeqBits+1:0] src, dst, endp, base, pa, pb, best;
  logic [ValueBits-1:0]      bestv, va;
  logic                      rd_ok, fnd;
  logic [IdxBits-1:0]        ridx;
  logic [ValueBits-1:0]      rval;

  logic signed [SeqBits+1:0] slo, shi, ssh, slen;
  assign slo  = {3'b000, lo};
  assign shi  = {3'b000, hi};
  assign ssh  = {3'b000, sh};
  assign slen = {3'b000, len};

  function automatic logic inr(input logic signed [SeqBits+1:0] p);
    return p >= 1 && p <= Capacity;
  endfunction

  function automatic logic [AddrBits-1:0] addr(input logic signed [SeqBits+1:0] p);
    logic signed [SeqBits+1:0] q;
    q = p - One;
    return q[AddrBits-1:0];
  endfunction

  // Scanned element, zero when outside the store.
  logic [ValueBits-1:0] e;
  assign e = rd_ok ? rdata : '0;

  logic pass;
  always_comb begin
    case (kind)
      CMP_EQ:  pass = e == key;
      CMP_NE:  pass = e != key;
      CMP_GE:  pass = e >= key;
      CMP_GT:  pass = e > key;
      CMP_LE:  pass = e <= key;
      CMP_LT:  pass = e < key;
      default: pass = 1'b0;
    endcase
  end

  logic better;
  always_comb begin
    case (op)
      OP_MAXIDX, OP_SORTDESC: better = e >= bestv;
      default:                better = e <= bestv;
    endcase
  end

  logic is_search;
  assign is_search = (op == OP_SRCHUP) || (op == OP_SRCHDN);

  // Step direction of a copy or scan.
  logic down;
  assign down = (op == OP_SHIFTR) || (op == OP_SRCHDN);

  // The end pointer is inclusive: range_open tests the current element,
  // next_open tests the one after it.
  assign status.op         = op;
  assign status.range_open = down ? (src >= endp) : (src <= endp);
  assign status.next_open  = down ? (src > endp) : (src < endp);
  assign status.hit        = is_search && pass;
  assign status.sort_more  = (op == OP_REVERSE) ? (pa < pb) : (base < shi);

  // Memory port control.
  always_comb begin
    raddr = addr(src);
    we    = 1'b0;
    waddr = addr(dst);
    wdata = rdata;
    if (cmd.load) begin
      raddr = in_first[AddrBits-1:0] - 1'b1;
      we    = (in_opcode == OP_WRITE) && in_first >= 1 && in_first <= Capacity;
      waddr = in_first[AddrBits-1:0] - 1'b1;
      wdata = in_value;
    end else if (cmd.swap_rda) begin
      raddr = addr(pa);
    end else if (cmd.swap_rdb) begin
      raddr = addr(pb);
    end else if (cmd.swap_wra) begin
      we    = inr(pa) && inr(pb);
      waddr = addr(pa);
      wdata = rdata;
    end else if (cmd.swap_wrb) begin
      we    = inr(pa) && inr(pb);
      waddr = addr(pb);
      wdata = va;
    end else if (cmd.copy_wr) begin
      we    = inr(dst);
      wdata = e;
    end
  end

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.load && in_opcode == OP_SETLEN) begin
      len <= (in_value > Capacity) ? IdxBits'(Capacity) : in_value[IdxBits-1:0];
    end else if (cmd.init && op == OP_TAIL) begin
      len <= (len != 0) ? len - 1'b1 : len;
    end else if (cmd.init && op == OP_CUT) begin
      len <= (lo >= len) ? '0 : len - lo;
    end
  end

  // Pointer and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= opcode_t'(in_opcode);
      lo    <= in_first;
      hi    <= in_last;
      sh    <= in_shift;
      key   <= in_value;
      kind  <= in_kind;
      rd_ok <= in_first >= 1 && in_first <= Capacity;
      fnd   <= 1'b0;
      pa    <= {3'b000, in_first};
      pb    <= {3'b000, in_last};
    end
    if (cmd.load && in_opcode == OP_READ) begin
      rval <= '0;
    end
    if (cmd.init) begin
      base <= slo;
      case (op)
        OP_TAIL: begin
          src <= One + One; endp <= slen; dst <= One;
        end
        OP_CUT: begin
          src <= slo + One; endp <= (lo == 0) ? '0 : slen; dst <= One;
        end
        OP_SHIFTR: begin
          src <= shi; endp <= slo; dst <= shi + ssh;
        end
        OP_SHIFTL: begin
          src <= slo; endp <= shi; dst <= slo - ssh;
        end
        OP_SRCHDN: begin
          src <= shi; endp <= slo;
        end
        OP_MAXIDX, OP_MINIDX, OP_SORTASC, OP_SORTDESC, OP_SRCHUP: begin
          src <= slo; endp <= shi;
          best  <= slo;
          bestv <= (op == OP_MAXIDX || op == OP_SORTDESC) ? '0 : VMax;
        end
        default: begin
          src <= slo; endp <= shi;
        end
      endcase
      if (op == OP_READ) begin
        rval <= rd_ok ? rdata : '0;
      end
    end
    if (cmd.copy_rd) begin
      rd_ok <= inr(src);
    end
    if (cmd.copy_wr) begin
      src <= down ? src - One : src + One;
      dst <= down ? dst - One : dst + One;
    end
    if (cmd.scan_rd) begin
      rd_ok <= inr(src);
    end
    if (cmd.scan_chk) begin
      if (is_search) begin
        if (pass) begin
          fnd  <= 1'b1;
          best <= src;
        end
      end else if (better) begin
        best  <= src;
        bestv <= e;
      end
      src <= down ? src - One : src + One;
      pa  <= base;
    end
    if (cmd.scan_chk && !(status.next_open && !status.hit) &&
        (op == OP_SORTASC || op == OP_SORTDESC)) begin
      pb <= (better) ? src : best;
    end
    if (cmd.swap_rdb) begin
      va <= rdata;
    end
    if (cmd.sort_next) begin
      if (op == OP_REVERSE) begin
        pa <= pa + One;
        pb <= pb - One;
      end else begin
        base  <= base + One;
        src   <= base + One;
        best  <= base + One;
        bestv <= (op == OP_SORTDESC) ? '0 : VMax;
      end
    end
    if (cmd.finish) begin
      case (op)
        OP_MAXIDX, OP_MINIDX: ridx <= best[IdxBits-1:0];
        OP_SRCHUP: ridx <= fnd ? best[IdxBits-1:0] : hi + 1'b1;
        OP_SRCHDN: ridx <= fnd ? best[IdxBits-1:0] : lo - 1'b1;
        default:   ridx <= '0;
      endcase
      if (op != OP_READ) begin
        rval <= '0;
      end
    end
  end

  // Result outputs.
  assign found          = fnd;
  assign result_index   = ridx;
  assign read_value     = rval;
  assign current_length = len;

endmodule
`default_nettype wire

// File: hw/rtl/bounded_sequence_engine.sv
// Top level of the bounded sequence engine: controller plus datapath.
//
//  channel | direction | payload
//  req     | in        | opcode, first_index, last_index, shift_amount, operand_value,
//          |           | compare_kind
//  rsp     | out       | found, result_index, read_value, current_length
//
// One request is worked at a time. Simple opcodes pass through decode, dispatch and done
// before their result is presented; copies step each element through a read and a write
// state, scans through a read and a check state, swaps through two reads and two writes;
// a sort runs the shared scan-and-swap loop once per base position.
// Reset clears the length and the controller; element contents are undefined until
// written. The result is held until its transfer; no request is taken meanwhile.
`default_nettype none
module bounded_sequence_engine
  import bse_pkg::*;
(
  input wire clk,
  input wire rst,
  bse_req_if.sink   req,
  bse_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bse_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_opcode      (req.opcode),
    .in_first       (req.first_index),
    .in_last        (req.last_index),
    .in_shift       (req.shift_amount),
    .in_value       (req.operand_value),
    .in_kind        (req.compare_kind),
    .found          (rsp.found),
    .result_index   (rsp.result_index),
    .read_value     (rsp.read_value),
    .current_length (rsp.current_length)
  );

  // Request and result transfers never coincide.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("request taken while result pending");

  // A request transfer leads to a result only after some work.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !rsp.valid) else $error("result too early");

  // Length never exceeds the capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    rsp.current_length <= Capacity) else $error("length above capacity");

endmodule
`default_nettype wire
